// ----- hdl/dfe_pkg.sv -----
// ----------------------------------------------------------------------------
// DShot frame encoder package
// Shared request/item types, register map, reset values and frame helpers.
// ----------------------------------------------------------------------------
package dfe_pkg;

  // Field widths
  localparam int unsigned ValueW   = 11;
  localparam int unsigned HighW    = 15;
  localparam int unsigned LowW     = 16;
  localparam int unsigned FrameW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Items per frame: one per frame bit plus the closing pause
  localparam int unsigned BitItems = FrameW;
  localparam int unsigned CntW     = $clog2(BitItems + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(BitItems);

  // Request opcodes
  localparam logic OP_THROTTLE = 1'b0;
  localparam logic OP_RAW      = 1'b1;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ONE_HIGH   = 3'd0,
    REG_ONE_LOW    = 3'd1,
    REG_ZERO_HIGH  = 3'd2,
    REG_ZERO_LOW   = 3'd3,
    REG_PAUSE      = 3'd4,
    REG_THR_FLOOR  = 3'd5,
    REG_THR_CEIL   = 3'd6
  } reg_idx_t;

  // Reset values
  localparam logic [HighW-1:0]  RST_ONE_HIGH  = 15'd10;
  localparam logic [HighW-1:0]  RST_ONE_LOW   = 15'd6;
  localparam logic [HighW-1:0]  RST_ZERO_HIGH = 15'd5;
  localparam logic [HighW-1:0]  RST_ZERO_LOW  = 15'd11;
  localparam logic [LowW-1:0]   RST_PAUSE     = 16'd3200;
  localparam logic [ValueW-1:0] RST_FLOOR     = 11'd48;
  localparam logic [ValueW-1:0] RST_CEIL      = 11'd2047;

  // Motor request
  typedef struct packed {
    logic              opcode;
    logic [ValueW-1:0] value;
    logic              telemetry;
  } dfe_in_t;

  // Line item: one bit pulse or the closing pause
  typedef struct packed {
    logic [HighW-1:0]  high_ticks;
    logic [LowW-1:0]   low_ticks;
    logic [FrameW-1:0] frame_word;
    logic              last;
  } dfe_out_t;

  // XOR of the three nibbles of the 12-bit value/telemetry word
  function automatic logic [3:0] nibble_xor(input logic [ValueW:0] word12);
    return word12[3:0] ^ word12[7:4] ^ word12[11:8];
  endfunction

endpackage

// ----- hdl/dfe_frame_build.sv -----
// ----------------------------------------------------------------------------
// DShot frame builder
// Clamps throttle requests and assembles the 16-bit frame with its checksum.
// ----------------------------------------------------------------------------
module dfe_frame_build
  import dfe_pkg::*;
(
  input  dfe_in_t           req,
  input  logic [ValueW-1:0] thr_floor,
  input  logic [ValueW-1:0] thr_ceil,
  output logic [FrameW-1:0] frame
);

  logic [ValueW-1:0] val;
  logic              tel;
  logic [ValueW:0]   word12;

  // Throttle clamp; ceiling test wins when floor is above ceiling
  always_comb begin
    val = req.value;
    tel = req.telemetry;
    if (req.opcode == OP_THROTTLE) begin
      tel = 1'b0;
      if (req.value > thr_ceil) begin
        val = thr_ceil;
      end else if (req.value < thr_floor) begin
        val = thr_floor;
      end
    end
  end

  // Frame: value, telemetry, checksum
  assign word12 = {val, tel};
  assign frame  = {word12, nibble_xor(word12)};

endmodule

// ----- hdl/dshot_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// DShot frame encoder
// Turns motor requests into timed line items for a pulse generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request (opcode, value, telemetry) per accepted transfer.
//   out_*  : 17 items per request: 16 bit pulses MSB first, each with the
//            high/low tick counts for a one or zero, then a low pause item
//            with last set. Every item carries the full frame word.
//   cfg_*  : register writes (index, data); always ready, unknown indexes
//            are dropped. Write only while no request is in flight.
// Path: the first item of a request reaches out_* through the frame register,
//   then the serializer registers, then the output register.
// Throughput: one item per cycle while out_ready stays high, set by the output
//   serializer. The frame register takes the next request while the current
//   one is still being sent, so back-to-back requests leave no gap.
// Reset: registers return to their defaults, all channels empty.
// Stall: when out_ready is low the current item holds; the serializer and
//   then the input side back up, in_ready drops once the frame register is
//   full.
// ----------------------------------------------------------------------------
module dshot_frame_encoder
  import dfe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  dfe_in_t             in_data,

  output logic                out_valid,
  input  logic                out_ready,
  output dfe_out_t            out_data,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // Configuration registers
  logic [HighW-1:0]  one_high_r, one_low_r, zero_high_r, zero_low_r;
  logic [LowW-1:0]   pause_r;
  logic [ValueW-1:0] floor_r, ceil_r;

  // Frame register
  logic              frm_valid_r;
  logic [FrameW-1:0] frm_word_r;
  logic [FrameW-1:0] frm_word_nxt;

  // Serializer
  logic              sh_busy_r;
  logic [CntW-1:0]   sh_cnt_r;
  logic [FrameW-1:0] sh_word_r;
  logic [FrameW-1:0] sh_bits_r;

  // Output register
  logic              out_valid_r;
  dfe_out_t          out_r;
  dfe_out_t          out_nxt;

  logic out_adv, ser_step, ser_done, ser_free, load_ser, in_take;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_high_r  <= RST_ONE_HIGH;
      one_low_r   <= RST_ONE_LOW;
      zero_high_r <= RST_ZERO_HIGH;
      zero_low_r  <= RST_ZERO_LOW;
      pause_r     <= RST_PAUSE;
      floor_r     <= RST_FLOOR;
      ceil_r      <= RST_CEIL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  one_high_r  <= cfg_data[HighW-1:0];
        REG_ONE_LOW:   one_low_r   <= cfg_data[HighW-1:0];
        REG_ZERO_HIGH: zero_high_r <= cfg_data[HighW-1:0];
        REG_ZERO_LOW:  zero_low_r  <= cfg_data[HighW-1:0];
        REG_PAUSE:     pause_r     <= cfg_data[LowW-1:0];
        REG_THR_FLOOR: floor_r     <= cfg_data[ValueW-1:0];
        REG_THR_CEIL:  ceil_r      <= cfg_data[ValueW-1:0];
        default: ;
      endcase
    end
  end

  // Frame assembly
  dfe_frame_build u_build (
    .req       (in_data),
    .thr_floor (floor_r),
    .thr_ceil  (ceil_r),
    .frame     (frm_word_nxt)
  );

  // Handshake flow
  assign out_adv  = !out_valid_r || out_ready;
  assign ser_step = sh_busy_r && out_adv;
  assign ser_done = ser_step && (sh_cnt_r == LastIdx);
  assign ser_free = !sh_busy_r || ser_done;
  assign load_ser = frm_valid_r && ser_free;
  assign in_ready = !frm_valid_r || load_ser;
  assign in_take  = in_valid && in_ready;

  // Frame register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
    end else if (in_take) begin
      frm_valid_r <= 1'b1;
    end else if (load_ser) begin
      frm_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frm_word_r <= frm_word_nxt;
    end
  end

  // Serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_busy_r <= 1'b0;
      sh_cnt_r  <= '0;
    end else if (load_ser) begin
      sh_busy_r <= 1'b1;
      sh_cnt_r  <= '0;
    end else if (ser_done) begin
      sh_busy_r <= 1'b0;
      sh_cnt_r  <= '0;
    end else if (ser_step) begin
      sh_cnt_r  <= sh_cnt_r + 1'b1;
    end
  end

  // Serializer data: shift out MSB first
  always_ff @(posedge clk) begin
    if (load_ser) begin
      sh_word_r <= frm_word_r;
      sh_bits_r <= frm_word_r;
    end else if (ser_step) begin
      sh_bits_r <= {sh_bits_r[FrameW-2:0], 1'b0};
    end
  end

  // Next line item
  always_comb begin
    out_nxt.frame_word = sh_word_r;
    if (sh_cnt_r == LastIdx) begin
      out_nxt.high_ticks = '0;
      out_nxt.low_ticks  = pause_r;
      out_nxt.last       = 1'b1;
    end else if (sh_bits_r[FrameW-1]) begin
      out_nxt.high_ticks = one_high_r;
      out_nxt.low_ticks  = {1'b0, one_low_r};
      out_nxt.last       = 1'b0;
    end else begin
      out_nxt.high_ticks = zero_high_r;
      out_nxt.low_ticks  = {1'b0, zero_low_r};
      out_nxt.last       = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= sh_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_step) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    sh_busy_r |-> sh_cnt_r <= LastIdx)
    else $error("serializer count out of range");

  a_frame_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_r.last |=>
      out_valid_r && out_r.frame_word == $past(out_r.frame_word))
    else $error("frame changed or gap inside a frame");

  a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.frame_word[3:0] ==
      nibble_xor(out_r.frame_word[FrameW-1:4]))
    else $error("frame checksum mismatch");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> frm_valid_r && sh_busy_r)
    else $error("input stalled with free buffering");

endmodule
